### sv/assert_macros.svh
// Assertion helpers for the RTL files; dtach_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/dtach_pkg.sv
`default_nettype none
package dtach_pkg;

    // Counter width default
    localparam int COUNT_BITS_DEF = 16;

    // Field widths
    localparam int WIN_W   = 16;
    localparam int EGAIN_W = 17;
    localparam int RGAIN_W = 16;
    localparam int VAL_W   = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    // Register reset values
    localparam logic [WIN_W-1:0]   WINDOW_RST    = 16'd710;
    localparam logic [EGAIN_W-1:0] EDGE_GAIN_RST = 17'd69927;
    localparam logic [RGAIN_W-1:0] RPM_GAIN_RST  = 16'd13964;
    localparam logic [VAL_W-1:0]   RPM_LIMIT_RST = 8'd80;

    // rpm to drive factor, Q16 (about 1.5875)
    localparam logic [EGAIN_W-1:0] DRIVE_GAIN = 17'd104039;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_WINDOW    = 2'd0,
        REG_EDGE_GAIN = 2'd1,
        REG_RPM_GAIN  = 2'd2,
        REG_RPM_LIMIT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [WIN_W-1:0]   window_ticks;
        logic [EGAIN_W-1:0] edge_gain;
        logic [RGAIN_W-1:0] rpm_gain;
        logic [VAL_W-1:0]   rpm_limit;
    } t_cfg;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } t_state;

    // Multiplier schedule: each step after the first consumes the last product; each before FINISH issues one
    typedef enum logic [2:0] {
        STEP_R_EDGE  = 3'd0,
        STEP_R_RPM   = 3'd1,
        STEP_R_DRIVE = 3'd2,
        STEP_L_EDGE  = 3'd3,
        STEP_L_RPM   = 3'd4,
        STEP_L_DRIVE = 3'd5,
        STEP_FINISH  = 3'd6
    } t_step;

endpackage
`default_nettype wire

### sv/dtach_cfg_regs.sv
`default_nettype none
module dtach_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dtach_pkg::APB_AW-1:0]  paddr,
    input  wire logic [dtach_pkg::APB_DW-1:0]  pwdata,
    output logic      [dtach_pkg::APB_DW-1:0]  prdata,
    output logic                               pready,
    output dtach_pkg::t_cfg                    o_cfg
);
    import dtach_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ticks <= WINDOW_RST;
            r_cfg.edge_gain    <= EDGE_GAIN_RST;
            r_cfg.rpm_gain     <= RPM_GAIN_RST;
            r_cfg.rpm_limit    <= RPM_LIMIT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_WINDOW:    r_cfg.window_ticks <= pwdata[WIN_W-1:0];
                REG_EDGE_GAIN: r_cfg.edge_gain    <= pwdata[EGAIN_W-1:0];
                REG_RPM_GAIN:  r_cfg.rpm_gain     <= pwdata[RGAIN_W-1:0];
                REG_RPM_LIMIT: r_cfg.rpm_limit    <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_WINDOW:    prdata = APB_DW'(r_cfg.window_ticks);
            REG_EDGE_GAIN: prdata = APB_DW'(r_cfg.edge_gain);
            REG_RPM_GAIN:  prdata = APB_DW'(r_cfg.rpm_gain);
            REG_RPM_LIMIT: prdata = APB_DW'(r_cfg.rpm_limit);
            default:       prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### sv/dtach_mul.sv
`default_nettype none
// Shared multiply unit: registered product, then Q16 shift and clamp to 255.
module dtach_mul #(
    parameter int COUNT_BITS = dtach_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic [COUNT_BITS-1:0]           i_a,
    input  wire logic [dtach_pkg::EGAIN_W-1:0]   i_b,
    output logic      [dtach_pkg::VAL_W-1:0]     o_sat
);
    import dtach_pkg::*;

    localparam int PROD_W = COUNT_BITS + EGAIN_W;

    logic [PROD_W-1:0] r_prod;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    // Drop the fraction and clamp
    always_comb begin
        if (r_prod[PROD_W-1:16+VAL_W] != '0) begin
            o_sat = '1;
        end else begin
            o_sat = r_prod[16+VAL_W-1:16];
        end
    end

endmodule
`default_nettype wire

### sv/dtach_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module dtach_ctrl #(
    parameter int COUNT_BITS = dtach_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dtach_pkg::t_cfg               i_cfg,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic                          i_phase_right,
    input  wire logic                          i_phase_left,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic      [4*dtach_pkg::VAL_W-1:0] o_m_tdata,
    output logic                               o_m_done,
    output logic      [COUNT_BITS-1:0]         o_mul_a,
    output logic      [dtach_pkg::EGAIN_W-1:0] o_mul_b,
    input  wire logic [dtach_pkg::VAL_W-1:0]   i_mul_sat
);
    import dtach_pkg::*;

    localparam int CMP_W = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    t_state                r_state, n_state;
    t_step                 r_step, n_step;
    logic                  r_prev_r, n_prev_r, r_prev_l, n_prev_l;
    logic [COUNT_BITS-1:0] r_edges_r, n_edges_r, r_edges_l, n_edges_l;
    logic [COUNT_BITS-1:0] r_tick, n_tick;
    logic [VAL_W-1:0]      r_spd_r, n_spd_r, r_spd_l, n_spd_l;
    logic [VAL_W-1:0]      r_drv_r, n_drv_r, r_drv_l, n_drv_l;
    logic                  r_valid, n_valid, r_done, n_done;

    logic             w_s_acc, w_m_acc, w_close;
    logic [VAL_W-1:0] w_rpm;
    logic             w_calc, w_fresh, w_finish, w_cleared;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_valid || i_m_tready);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_m_acc    = r_valid && i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_done   = r_done;
    assign o_m_tdata  = {r_drv_l, r_drv_r, r_spd_l, r_spd_r};

    // Clamp rpm to the configured limit
    assign w_rpm = (i_mul_sat > i_cfg.rpm_limit) ? i_cfg.rpm_limit : i_mul_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= STEP_R_EDGE;
            r_prev_r  <= 1'b0;
            r_prev_l  <= 1'b0;
            r_edges_r <= '0;
            r_edges_l <= '0;
            r_tick    <= '0;
            r_spd_r   <= '0;
            r_spd_l   <= '0;
            r_drv_r   <= '0;
            r_drv_l   <= '0;
            r_valid   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_prev_r  <= n_prev_r;
            r_prev_l  <= n_prev_l;
            r_edges_r <= n_edges_r;
            r_edges_l <= n_edges_l;
            r_tick    <= n_tick;
            r_spd_r   <= n_spd_r;
            r_spd_l   <= n_spd_l;
            r_drv_r   <= n_drv_r;
            r_drv_l   <= n_drv_l;
            r_valid   <= n_valid;
            r_done    <= n_done;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_prev_r  = r_prev_r;
        n_prev_l  = r_prev_l;
        n_edges_r = r_edges_r;
        n_edges_l = r_edges_l;
        n_tick    = r_tick;
        n_spd_r   = r_spd_r;
        n_spd_l   = r_spd_l;
        n_drv_r   = r_drv_r;
        n_drv_l   = r_drv_l;
        n_valid   = r_valid && !w_m_acc;
        n_done    = r_done;
        w_close   = 1'b0;
        o_mul_a   = r_edges_r;
        o_mul_b   = i_cfg.edge_gain;

        case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    // Count rising edges and the tick
                    if (i_phase_right && !r_prev_r && r_edges_r != CMAX) begin
                        n_edges_r = r_edges_r + COUNT_BITS'(1);
                    end
                    if (i_phase_left && !r_prev_l && r_edges_l != CMAX) begin
                        n_edges_l = r_edges_l + COUNT_BITS'(1);
                    end
                    n_prev_r = i_phase_right;
                    n_prev_l = i_phase_left;
                    if (r_tick != CMAX) begin
                        n_tick = r_tick + COUNT_BITS'(1);
                    end
                    w_close = (CMP_W'(n_tick) >= CMP_W'(i_cfg.window_ticks))
                              || (n_tick == CMAX);
                    if (w_close) begin
                        n_state = ST_CALC;
                        n_step  = STEP_R_EDGE;
                        n_valid = 1'b0;
                    end else begin
                        n_valid = 1'b1;
                        n_done  = 1'b0;
                    end
                end
            end
            ST_CALC: begin
                n_step = t_step'(r_step + 3'd1);
                case (r_step)
                    STEP_R_EDGE: begin
                        o_mul_a = r_edges_r;
                        o_mul_b = i_cfg.edge_gain;
                    end
                    STEP_R_RPM: begin
                        o_mul_a = COUNT_BITS'(i_mul_sat);
                        o_mul_b = EGAIN_W'(i_cfg.rpm_gain);
                    end
                    STEP_R_DRIVE: begin
                        n_spd_r = w_rpm;
                        o_mul_a = COUNT_BITS'(w_rpm);
                        o_mul_b = DRIVE_GAIN;
                    end
                    STEP_L_EDGE: begin
                        n_drv_r = i_mul_sat;
                        o_mul_a = r_edges_l;
                        o_mul_b = i_cfg.edge_gain;
                    end
                    STEP_L_RPM: begin
                        o_mul_a = COUNT_BITS'(i_mul_sat);
                        o_mul_b = EGAIN_W'(i_cfg.rpm_gain);
                    end
                    STEP_L_DRIVE: begin
                        n_spd_l = w_rpm;
                        o_mul_a = COUNT_BITS'(w_rpm);
                        o_mul_b = DRIVE_GAIN;
                    end
                    STEP_FINISH: begin
                        // Store the last value, clear the window, present the item
                        n_drv_l   = i_mul_sat;
                        n_edges_r = '0;
                        n_edges_l = '0;
                        n_tick    = '0;
                        n_valid   = 1'b1;
                        n_done    = 1'b1;
                        n_state   = ST_IDLE;
                        n_step    = STEP_R_EDGE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                        n_step  = STEP_R_EDGE;
                    end
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer conditions watched by the checks below
    assign w_calc    = (r_state == ST_CALC);
    assign w_fresh   = w_calc && !r_valid && (r_step == STEP_R_EDGE);
    assign w_finish  = w_calc && (r_step == STEP_FINISH);
    assign w_cleared = (r_tick == '0) && (r_edges_r == '0) && (r_edges_l == '0);

    `ASSERT_NXT(a_close_enters_calc, i_clk, i_rst_n, w_s_acc && w_close, w_fresh)
    `ASSERT_NXT(a_open_item_out, i_clk, i_rst_n, w_s_acc && !w_close, r_valid && !r_done && !w_calc)
    `ASSERT_NXT(a_finish_clears, i_clk, i_rst_n, w_finish, r_valid && r_done && w_cleared)
    `ASSERT_IMP(a_no_accept_in_calc, i_clk, i_rst_n, w_calc, !o_s_tready && !r_valid)

endmodule
`default_nettype wire

### sv/dual_encoder_tachometer_core.sv
`default_nettype none
// Two-wheel tachometer. Each input item is one sample tick carrying both encoder A-phase
// levels (tdata bit 0 right, bit 1 left); every item yields exactly one output item with
// the held speed and drive values of both wheels and a window-done flag in tuser. Ticks
// that do not close the window can be accepted back to back while the output is taken. A tick
// that closes it is followed by seven sequencer steps, because all six products (edge correction,
// rpm, drive, per wheel) go one after another through a single registered multiplier. Input
// is not ready during those steps. Configuration sits on a small APB port, register i at
// byte address 4*i, and should be written only while the block is idle.
module dual_encoder_tachometer_core #(
    parameter int COUNT_BITS = dtach_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dtach_pkg::APB_AW-1:0]  paddr,
    input  wire logic [dtach_pkg::APB_DW-1:0]  pwdata,
    output logic      [dtach_pkg::APB_DW-1:0]  prdata,
    output logic                               pready,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [0] phase_a_right, [1] phase_a_left, [7:2] zero
    input  wire logic [7:0]                    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [7:0] speed_right, [15:8] speed_left, [23:16] drive_right, [31:24] drive_left
    output logic      [4*dtach_pkg::VAL_W-1:0] o_m_axis_tdata,
    // [0] window_done
    output logic      [0:0]                    o_m_axis_tuser
);
    import dtach_pkg::*;

    t_cfg                  w_cfg;
    logic [COUNT_BITS-1:0] w_mul_a;
    logic [EGAIN_W-1:0]    w_mul_b;
    logic [VAL_W-1:0]      w_mul_sat;
    logic                  w_done;

    assign o_m_axis_tuser = w_done;

    dtach_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dtach_mul #(
        .COUNT_BITS (COUNT_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_sat (w_mul_sat)
    );

    dtach_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_s_tvalid    (i_s_axis_tvalid),
        .o_s_tready    (o_s_axis_tready),
        .i_phase_right (i_s_axis_tdata[0]),
        .i_phase_left  (i_s_axis_tdata[1]),
        .o_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .o_m_tdata     (o_m_axis_tdata),
        .o_m_done      (w_done),
        .o_mul_a       (w_mul_a),
        .o_mul_b       (w_mul_b),
        .i_mul_sat     (w_mul_sat)
    );

endmodule
`default_nettype wire

### tb/sv/dual_encoder_tachometer_core_tb.sv
`timescale 1ns / 1ps
module dual_encoder_tachometer_core_tb;
    import dtach_pkg::*;

    localparam int CNT_BITS          = COUNT_BITS_DEF;
    localparam int STALL_LIMIT       = 4000;
    localparam int SETTLE_CYCLES     = 12;
    localparam int LONG_HOLD         = 300;
    localparam int LONG_WINDOW_TICKS = 264;
    localparam int SETTING_TICKS     = 40;
    localparam int MAX_REPORTS       = 30;
    localparam logic [CNT_BITS-1:0] CNT_FULL = '1;

    typedef struct packed {
        logic [VAL_W-1:0] speed_r, speed_l, drive_r, drive_l;
        logic             done;
    } t_reading;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_reg_idx    idx;
        logic [31:0] value;
        logic [1:0]  phase;
        bit          typed;
        t_reading    want;
    } t_row;

    localparam t_reading HELD_ZERO   = '0;
    localparam t_reading CLOSED_ZERO = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b1};

    // Directed ticks and register writes: phase is {left, right}; typed rows carry their own expectation
    t_row directed_rows [30] = '{
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b00, 1'b1, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b01, 1'b1, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b10, 1'b1, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b11, 1'b1, HELD_ZERO},
        '{ROW_CFG,  REG_WINDOW,    32'd0,        2'b00, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b00, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b11, 1'b0, HELD_ZERO},
        '{ROW_CFG,  REG_EDGE_GAIN, 32'hFFFF_FFFF, 2'b00, 1'b0, HELD_ZERO},
        '{ROW_CFG,  REG_RPM_GAIN,  32'hFFFF_FFFF, 2'b00, 1'b0, HELD_ZERO},
        '{ROW_CFG,  REG_RPM_LIMIT, 32'hFFFF_FFFF, 2'b00, 1'b0, HELD_ZERO},
        '{ROW_CFG,  REG_WINDOW,    32'd1,        2'b00, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b01, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b10, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b11, 1'b0, HELD_ZERO},
        '{ROW_CFG,  REG_WINDOW,    32'd6,        2'b00, 1'b0, HELD_ZERO},
        '{ROW_CFG,  REG_EDGE_GAIN, 32'd0,        2'b00, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b01, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b10, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b01, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b10, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b01, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b10, 1'b1, CLOSED_ZERO},
        '{ROW_CFG,  REG_EDGE_GAIN, 32'h0001_FFFF, 2'b00, 1'b0, HELD_ZERO},
        '{ROW_CFG,  REG_RPM_LIMIT, 32'd0,        2'b00, 1'b0, HELD_ZERO},
        '{ROW_CFG,  REG_WINDOW,    32'd2,        2'b00, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b01, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b10, 1'b1, CLOSED_ZERO},
        '{ROW_CFG,  REG_RPM_LIMIT, 32'h0000_00FF, 2'b00, 1'b0, HELD_ZERO},
        '{ROW_CFG,  REG_WINDOW,    32'hFFFF_0010, 2'b00, 1'b0, HELD_ZERO},
        '{ROW_TICK, REG_WINDOW,    32'd0,        2'b11, 1'b0, HELD_ZERO}
    };

    // DUT ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_AW-1:0]       paddr;
    logic [APB_DW-1:0]       pwdata;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [7:0]              i_s_axis_tdata;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [4*VAL_W-1:0]      o_m_axis_tdata;
    logic [0:0]              o_m_axis_tuser;

    // Expectation attached to the item on the bus
    logic                    row_typed;
    t_reading                row_want;

    // Predictor copy of configuration and state
    logic [WIN_W-1:0]        cfg_window    = WINDOW_RST;
    logic [EGAIN_W-1:0]      cfg_edge_gain = EDGE_GAIN_RST;
    logic [RGAIN_W-1:0]      cfg_rpm_gain  = RPM_GAIN_RST;
    logic [VAL_W-1:0]        cfg_rpm_limit = RPM_LIMIT_RST;
    logic                    prev_r = 1'b0;
    logic                    prev_l = 1'b0;
    logic [CNT_BITS-1:0]     edges_r = '0;
    logic [CNT_BITS-1:0]     edges_l = '0;
    logic [CNT_BITS-1:0]     ticks = '0;
    t_reading                held = '0;

    t_reading                pending_readings[$];
    int                      mismatches = 0;
    int                      ticks_taken = 0;
    int                      windows_seen = 0;
    int                      settings_written = 0;
    int                      send_idle_pct = 0;
    int                      recv_stall_pct = 0;
    int                      hold_req_n = 0;
    int                      hold_ack_n = 0;
    int                      hold_left = 0;
    int                      quiet_cycles = 0;

    dual_encoder_tachometer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    endtask

    // Correct edges, convert to rpm, clamp, scale to drive units
    function automatic void scale_wheel(input logic [CNT_BITS-1:0] edges,
                                        output logic [VAL_W-1:0] speed,
                                        output logic [VAL_W-1:0] drive);
        logic [63:0] prod;
        logic [63:0] corrected;
        logic [63:0] rpm;
        prod = (64'(edges) * 64'(cfg_edge_gain)) >> 16;
        corrected = (prod > 64'd255) ? 64'd255 : prod;
        prod = (corrected * 64'(cfg_rpm_gain)) >> 16;
        rpm = (prod > 64'd255) ? 64'd255 : prod;
        if (rpm > 64'(cfg_rpm_limit))
            rpm = 64'(cfg_rpm_limit);
        prod = (rpm * 64'(DRIVE_GAIN)) >> 16;
        speed = rpm[VAL_W-1:0];
        drive = (prod > 64'd255) ? 8'd255 : prod[VAL_W-1:0];
    endfunction

    // Count edges and the tick; close the window when the count reaches its length or saturates
    function automatic t_reading advance_tick(input logic a_r, input logic a_l);
        if (a_r && !prev_r && edges_r != CNT_FULL)
            edges_r++;
        if (a_l && !prev_l && edges_l != CNT_FULL)
            edges_l++;
        prev_r = a_r;
        prev_l = a_l;
        if (ticks != CNT_FULL)
            ticks++;
        held.done = 1'b0;
        if (32'(ticks) >= 32'(cfg_window) || ticks == CNT_FULL) begin
            scale_wheel(edges_r, held.speed_r, held.drive_r);
            scale_wheel(edges_l, held.speed_l, held.drive_l);
            edges_r = '0;
            edges_l = '0;
            ticks = '0;
            held.done = 1'b1;
        end
        return held;
    endfunction

    task automatic check_reading(input t_reading got);
        t_reading want;
        if (got.done)
            windows_seen++;
        if (pending_readings.size() == 0) begin
            report_mismatch("result with no tick pending", 1, 0);
        end else begin
            want = pending_readings.pop_front();
            if (got.speed_r != want.speed_r)
                report_mismatch("speed_right", got.speed_r, want.speed_r);
            if (got.speed_l != want.speed_l)
                report_mismatch("speed_left", got.speed_l, want.speed_l);
            if (got.drive_r != want.drive_r)
                report_mismatch("drive_right", got.drive_r, want.drive_r);
            if (got.drive_l != want.drive_l)
                report_mismatch("drive_left", got.drive_l, want.drive_l);
            if (got.done != want.done)
                report_mismatch("window_done", got.done, want.done);
        end
    endtask

    // Predict on each accepted tick, check each accepted result
    always @(posedge i_clk) begin
        t_reading predicted;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predicted = advance_tick(i_s_axis_tdata[0], i_s_axis_tdata[1]);
                pending_readings.push_back(row_typed ? row_want : predicted);
                ticks_taken++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_reading({o_m_axis_tdata[7:0], o_m_axis_tdata[15:8],
                               o_m_axis_tdata[23:16], o_m_axis_tdata[31:24],
                               o_m_axis_tuser[0]});
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_ack_n != hold_req_n) begin
            hold_ack_n = hold_req_n;
            hold_left = LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one tick, idling first at the current rate, and hold until accepted
    task automatic send_tick(input logic [1:0] phase, input bit typed, input t_reading want);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, phase};
        row_typed       <= typed;
        row_want        <= want;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic quiesce();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write, then read back the masked value
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [APB_DW-1:0] field;
        logic [APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            REG_WINDOW: begin
                cfg_window = value[WIN_W-1:0];
                field = APB_DW'(cfg_window);
            end
            REG_EDGE_GAIN: begin
                cfg_edge_gain = value[EGAIN_W-1:0];
                field = APB_DW'(cfg_edge_gain);
            end
            REG_RPM_GAIN: begin
                cfg_rpm_gain = value[RGAIN_W-1:0];
                field = APB_DW'(cfg_rpm_gain);
            end
            REG_RPM_LIMIT: begin
                cfg_rpm_limit = value[VAL_W-1:0];
                field = APB_DW'(cfg_rpm_limit);
            end
            default: field = '0;
        endcase
        settings_written++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got != field)
            report_mismatch("register readback", got, field);
        @(posedge i_clk);
    endtask

    // Fill the bits above a register field with noise
    function automatic logic [31:0] with_noise(input logic [31:0] field, input int width);
        logic [31:0] noise;
        noise = $urandom;
        return (noise << width) | field;
    endfunction

    task automatic pick_setting();
        logic [WIN_W-1:0]   win;
        logic [EGAIN_W-1:0] egain;
        logic [RGAIN_W-1:0] rgain;
        logic [VAL_W-1:0]   lim;
        case ($urandom_range(7))
            0:       win = WIN_W'($urandom_range(1));
            1:       win = WIN_W'($urandom_range(600, 200));
            default: win = WIN_W'($urandom_range(24, 1));
        endcase
        case ($urandom_range(3))
            0:       egain = '0;
            1:       egain = '1;
            default: egain = EGAIN_W'($urandom);
        endcase
        case ($urandom_range(3))
            0:       rgain = '0;
            1:       rgain = '1;
            default: rgain = RGAIN_W'($urandom);
        endcase
        case ($urandom_range(3))
            0:       lim = '0;
            1:       lim = '1;
            default: lim = VAL_W'($urandom);
        endcase
        write_reg(REG_WINDOW, with_noise(32'(win), WIN_W));
        write_reg(REG_EDGE_GAIN, with_noise(32'(egain), EGAIN_W));
        write_reg(REG_RPM_GAIN, with_noise(32'(rgain), RGAIN_W));
        write_reg(REG_RPM_LIMIT, with_noise(32'(lim), VAL_W));
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        row_typed       <= 1'b0;
        row_want        <= HELD_ZERO;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset values, single edges, window extremes, gain and clamp extremes
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                quiesce();
                write_reg(directed_rows[r].idx, directed_rows[r].value);
            end else begin
                send_tick(directed_rows[r].phase, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // Long window at full gains, an edge every other tick: saturates corrected and drive
        quiesce();
        write_reg(REG_WINDOW, 32'(LONG_WINDOW_TICKS));
        write_reg(REG_EDGE_GAIN, 32'h0001_FFFF);
        write_reg(REG_RPM_GAIN, 32'h0000_FFFF);
        write_reg(REG_RPM_LIMIT, 32'h0000_00FF);
        for (int n = 0; n < LONG_WINDOW_TICKS + 2; n++)
            send_tick(n[0] ? 2'b11 : 2'b00, 1'b0, HELD_ZERO);

        // Random ticks under four idle patterns, three settings each
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 66; end
                default: begin send_idle_pct = 17; recv_stall_pct <= 17; end
            endcase
            for (int s = 0; s < 3; s++) begin
                quiesce();
                pick_setting();
                for (int n = 0; n < SETTING_TICKS; n++) begin
                    if (mode == 0 && s == 0 && n == 16)
                        hold_req_n <= hold_req_n + 1;
                    if (mode == 3 && s == 1 && n == 32)
                        quiesce();
                    send_tick(2'($urandom_range(3)), 1'b0, HELD_ZERO);
                end
            end
        end

        quiesce();
        if (pending_readings.size() != 0)
            report_mismatch("results still pending", pending_readings.size(), 0);
        $display("covered %0d ticks, %0d windows closed, %0d register writes",
                 ticks_taken, windows_seen, settings_written);
        $display("window lengths 0 to 600, gain and clamp extremes, long stall and drain");
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
